// ===== sv/nearest_object_visit_planner_core_defines.svh =====
// ----------------------------------------------------------------------------
// nearest_object_visit_planner_core_defines
// Assertion macros used by the visit planner datapath.
// ----------------------------------------------------------------------------
`ifndef NEAREST_OBJECT_VISIT_PLANNER_CORE_DEFINES_SVH
`define NEAREST_OBJECT_VISIT_PLANNER_CORE_DEFINES_SVH

// same-cycle implication
`define NOVP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NOVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/novp_pkg.sv =====
// ----------------------------------------------------------------------------
// novp_pkg
// Types, codes and helpers of the nearest object visit planner.
// ----------------------------------------------------------------------------
package novp_pkg;

	// operation codes
	typedef enum logic [1:0] {
		OP_POSE   = 2'd0,
		OP_MARKER = 2'd1,
		OP_EVAL   = 2'd2
	} op_t;

	// configuration register indexes
	localparam logic [1:0] CFG_REACH  = 2'd0;
	localparam logic [1:0] CFG_MARGIN = 2'd1;
	localparam logic [1:0] CFG_BUFFER = 2'd2;

	localparam logic [19:0] REACH_RST  = 20'd39322;
	localparam logic [19:0] MARGIN_RST = 20'd32768;
	localparam logic [19:0] BUFFER_RST = 20'd13107;

	// visit point codes
	localparam logic [1:0] PT_NORTH = 2'd0;
	localparam logic [1:0] PT_SOUTH = 2'd1;
	localparam logic [1:0] PT_EAST  = 2'd2;
	localparam logic [1:0] PT_WEST  = 2'd3;

	localparam logic [4:0] ISQRT_LAST = 5'd24;

	localparam logic signed [15:0] HZ_ONE   = 16'sd32767;
	localparam logic signed [15:0] HZ_HALF  = 16'sd23170;
	localparam logic [14:0]        HW_ONE   = 15'd32767;
	localparam logic [14:0]        HW_HALF  = 15'd23170;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] object_id;
		logic [23:0]        object_width;
		logic [23:0]        object_height;
		logic               is_add;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
		logic signed [31:0] goal_object;
		logic signed [15:0] heading_z;
		logic [14:0]        heading_w;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [19:0] value;
	} cfg_item_t;

	typedef struct packed {
		logic signed [31:0] id;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [24:0]        radius;
	} entry_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE,
		ST_M_RD, ST_M_CHK, ST_M_SQ, ST_M_SUM, ST_M_ROOT, ST_M_WR,
		ST_E_RD, ST_E_LOAD, ST_E_PT, ST_DWAIT, ST_E_CMP, ST_E_WB, ST_C_CMP, ST_E_PICK,
		ST_F_RD, ST_F_LOAD, ST_F_PT, ST_F_CMP, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_MARK, PH_CENTRE, PH_FINAL
	} phase_t;

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic set_pose;
		logic scan_init;
		logic eval_init;
		logic rd_entry;
		logic rd_tgt;
		logic inc_idx;
		logic sq_wh;
		logic root_init;
		logic root_step;
		logic wr_entry;
		logic load_marks;
		logic clr_k;
		logic inc_k;
		logic pt_load;
		logic pt_centre;
		logic mark_near;
		logic wr_marks;
		logic best_upd;
		logic pick;
		logic fbest_upd;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_fire;
		op_t  op;
		logic is_add;
		logic scan_end;
		logic full;
		logic id_match;
		logic root_last;
		logic mark_set;
		logic k_last;
		logic marks_full;
		logic has_target;
		logic out_free;
	} status_t;

	// centre plus or minus radius, saturated to 32 bits
	function automatic logic signed [31:0] sat_offset(input logic signed [31:0] c,
			input logic [24:0] r, input logic sub);
		logic [33:0] s;
		s = sub ? ({{2{c[31]}}, c} - {9'd0, r}) : ({{2{c[31]}}, c} + {9'd0, r});
		if (s[33:31] == 3'b000 || s[33:31] == 3'b111)
			return s[31:0];
		else if (s[33])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

endpackage

// ===== sv/novp_stream_if.sv =====
// ----------------------------------------------------------------------------
// novp_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface novp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/novp_ctrl.sv =====
// ----------------------------------------------------------------------------
// novp_ctrl
// Sequencer of the visit planner: pose update, marker insert, evaluate scan and goal pick.
// ----------------------------------------------------------------------------
module novp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  novp_pkg::status_t st,
	output novp_pkg::cmd_t    cmd
);
	import novp_pkg::*;

	state_t state_q, state_d;
	phase_t phase_q;
	logic [1:0] dly_q;

	// state register, distance wait counter and return phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_MARK;
			dly_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			dly_q   <= (state_q == ST_DWAIT) ? dly_q + 2'd1 : 2'd0;
			case (state_q)
				ST_E_PT: phase_q <= PH_MARK;
				ST_E_WB: phase_q <= PH_CENTRE;
				ST_F_PT: phase_q <= PH_FINAL;
				default: phase_q <= phase_q;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (st.in_fire) state_d = ST_DECODE;
			ST_DECODE: begin
				unique case (st.op)
					OP_POSE:   state_d = ST_IDLE;
					OP_MARKER: state_d = st.is_add ? ST_M_RD : ST_IDLE;
					OP_EVAL:   state_d = ST_E_RD;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_M_RD: begin
				if (st.scan_end) state_d = st.full ? ST_IDLE : ST_M_SQ;
				else state_d = ST_M_CHK;
			end
			ST_M_CHK:  state_d = st.id_match ? ST_IDLE : ST_M_RD;
			ST_M_SQ:   state_d = ST_M_SUM;
			ST_M_SUM:  state_d = ST_M_ROOT;
			ST_M_ROOT: if (st.root_last) state_d = ST_M_WR;
			ST_M_WR:   state_d = ST_IDLE;
			ST_E_RD:   state_d = st.scan_end ? ST_E_PICK : ST_E_LOAD;
			ST_E_LOAD: state_d = ST_E_PT;
			ST_E_PT: begin
				if (!st.mark_set) state_d = ST_DWAIT;
				else if (st.k_last) state_d = ST_E_WB;
			end
			ST_DWAIT: begin
				if (dly_q == 2'd2) begin
					unique case (phase_q)
						PH_MARK:   state_d = ST_E_CMP;
						PH_CENTRE: state_d = ST_C_CMP;
						PH_FINAL:  state_d = ST_F_CMP;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_E_CMP:  state_d = st.k_last ? ST_E_WB : ST_E_PT;
			ST_E_WB:   state_d = st.marks_full ? ST_E_RD : ST_DWAIT;
			ST_C_CMP:  state_d = ST_E_RD;
			ST_E_PICK: state_d = st.has_target ? ST_F_RD : ST_IDLE;
			ST_F_RD:   state_d = ST_F_LOAD;
			ST_F_LOAD: state_d = ST_F_PT;
			ST_F_PT: begin
				if (!st.mark_set) state_d = ST_DWAIT;
				else if (st.k_last) state_d = ST_EMIT;
			end
			ST_F_CMP:  state_d = st.k_last ? ST_EMIT : ST_F_PT;
			ST_EMIT:   if (st.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.in_ready = 1'b1;
			ST_DECODE: begin
				unique case (st.op)
					OP_POSE:   cmd.set_pose = 1'b1;
					OP_MARKER: cmd.scan_init = st.is_add;
					OP_EVAL:   cmd.eval_init = 1'b1;
					default:   cmd = '0;
				endcase
			end
			ST_M_RD:   cmd.rd_entry = !st.scan_end;
			ST_M_CHK:  cmd.inc_idx = !st.id_match;
			ST_M_SQ:   cmd.sq_wh = 1'b1;
			ST_M_SUM:  cmd.root_init = 1'b1;
			ST_M_ROOT: cmd.root_step = 1'b1;
			ST_M_WR:   cmd.wr_entry = 1'b1;
			ST_E_RD:   begin
				cmd.rd_entry = !st.scan_end;
				cmd.clr_k    = 1'b1;
			end
			ST_E_LOAD: cmd.load_marks = 1'b1;
			ST_E_PT: begin
				cmd.pt_load = !st.mark_set;
				cmd.inc_k   = st.mark_set && !st.k_last;
			end
			ST_DWAIT:  cmd = '0;
			ST_E_CMP: begin
				cmd.mark_near = 1'b1;
				cmd.inc_k     = !st.k_last;
			end
			ST_E_WB: begin
				cmd.wr_marks  = 1'b1;
				cmd.pt_centre = !st.marks_full;
				cmd.inc_idx   = st.marks_full;
			end
			ST_C_CMP: begin
				cmd.best_upd = 1'b1;
				cmd.inc_idx  = 1'b1;
			end
			ST_E_PICK: cmd.pick = 1'b1;
			ST_F_RD: begin
				cmd.rd_tgt = 1'b1;
				cmd.clr_k  = 1'b1;
			end
			ST_F_LOAD: cmd.load_marks = 1'b1;
			ST_F_PT: begin
				cmd.pt_load = !st.mark_set;
				cmd.inc_k   = st.mark_set && !st.k_last;
			end
			ST_F_CMP: begin
				cmd.fbest_upd = 1'b1;
				cmd.inc_k     = !st.k_last;
			end
			ST_EMIT:   cmd.emit = st.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

// ===== sv/novp_dp.sv =====
// ----------------------------------------------------------------------------
// novp_dp
// Datapath of the visit planner: object table, distance unit, square root
// unit, selection registers, configuration registers and the result register.
// ----------------------------------------------------------------------------
`include "nearest_object_visit_planner_core_defines.svh"

module novp_dp #(
	parameter int MAX_OBJECTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  novp_pkg::cmd_t    cmd,
	output novp_pkg::status_t st,
	novp_stream_if.sink       req,
	novp_stream_if.source     rsp,
	novp_stream_if.sink       cfg
);
	import novp_pkg::*;

	localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OBJECTS);

	// object table
	entry_t     ent_mem [MAX_OBJECTS];
	logic [3:0] mark_mem [MAX_OBJECTS];

	in_item_t           in_q;
	logic signed [31:0] robot_x_q, robot_y_q;
	logic [19:0]        reach_q, margin_q, buffer_q;
	logic [CNT_W-1:0]   count_q, idx_q;
	logic [1:0]         k_q;
	logic [39:0]        thr2_q;
	logic [47:0]        wsq_q, hsq_q;
	logic [49:0]        val_q;
	logic [26:0]        rem_q;
	logic [24:0]        root_q;
	logic [4:0]         step_q;
	entry_t             ent_rd_q;
	logic [3:0]         mk_rd_q, marks_q;
	logic signed [31:0] tgt_x_q, tgt_y_q;
	logic [31:0]        adx_s1, ady_s1;
	logic [63:0]        sqx_s2, sqy_s2;
	logic [64:0]        dist_s3;
	logic [64:0]        best_q, fbest_q;
	logic               have_best_q, fhave_q, act_open_q, active_valid_q;
	logic [IDX_W-1:0]   best_idx_q, active_idx_q, tgt_idx_q;
	logic signed [31:0] fpx_q, fpy_q;
	out_item_t          out_q;
	logic               out_valid_q;

	logic               in_fire, out_free, full;
	logic               mk_we, rd_en;
	logic [IDX_W-1:0]   mk_addr, rd_addr;
	logic [3:0]         mk_wd;
	logic signed [31:0] pt_x, pt_y;
	logic [28:0]        cand, trial;
	logic signed [32:0] ddx, ddy;
	logic               below_thr, dist_lt_best, dist_lt_fbest;
	logic               dxneg, dypos, dyneg;

	assign in_fire   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign full      = (count_q == CNT_MAX);
	assign req.ready = cmd.in_ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// status to the controller
	always_comb begin
		st.in_fire    = in_fire;
		st.op         = op_t'(in_q.operation);
		st.is_add     = in_q.is_add;
		st.scan_end   = (idx_q == count_q);
		st.full       = full;
		st.id_match   = (ent_rd_q.id == in_q.object_id);
		st.root_last  = (step_q == ISQRT_LAST);
		st.mark_set   = marks_q[k_q];
		st.k_last     = (k_q == PT_WEST);
		st.marks_full = (marks_q == 4'hf);
		st.has_target = (active_valid_q && act_open_q) || have_best_q;
		st.out_free   = out_free;
	end

	// table ports
	always_comb begin
		rd_en   = cmd.rd_entry || cmd.rd_tgt;
		rd_addr = cmd.rd_tgt ? tgt_idx_q : idx_q[IDX_W-1:0];
		mk_we   = cmd.wr_entry || cmd.wr_marks;
		mk_addr = cmd.wr_entry ? count_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
		mk_wd   = cmd.wr_entry ? 4'h0 : marks_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_entry) begin
			ent_mem[count_q[IDX_W-1:0]] <= '{id: in_q.object_id, cx: in_q.coord_x,
				cy: in_q.coord_y,
				radius: {1'b0, root_q[24:1]} + {5'd0, margin_q} + {5'd0, buffer_q}};
		end
		if (mk_we)
			mark_mem[mk_addr] <= mk_wd;
		if (rd_en) begin
			ent_rd_q <= ent_mem[rd_addr];
			mk_rd_q  <= mark_mem[rd_addr];
		end
	end

	// visit point of the entry just read
	always_comb begin
		pt_x = ent_rd_q.cx;
		pt_y = ent_rd_q.cy;
		case (k_q)
			PT_NORTH: pt_y = sat_offset(ent_rd_q.cy, ent_rd_q.radius, 1'b0);
			PT_SOUTH: pt_y = sat_offset(ent_rd_q.cy, ent_rd_q.radius, 1'b1);
			PT_EAST:  pt_x = sat_offset(ent_rd_q.cx, ent_rd_q.radius, 1'b0);
			default:  pt_x = sat_offset(ent_rd_q.cx, ent_rd_q.radius, 1'b1);
		endcase
	end

	// square root digit step
	assign cand  = {rem_q, val_q[49:48]};
	assign trial = {2'b00, root_q, 2'b01};

	// distance unit front end
	assign ddx = {robot_x_q[31], robot_x_q} - {tgt_x_q[31], tgt_x_q};
	assign ddy = {robot_y_q[31], robot_y_q} - {tgt_y_q[31], tgt_y_q};

	assign below_thr     = (dist_s3 < {25'd0, thr2_q});
	assign dist_lt_best  = (dist_s3 < best_q);
	assign dist_lt_fbest = (dist_s3 < fbest_q);

	// heading toward the centre from the chosen point
	assign dxneg = (fpx_q > ent_rd_q.cx);
	assign dypos = (ent_rd_q.cy > fpy_q);
	assign dyneg = (ent_rd_q.cy < fpy_q);

	// distance pipeline, free running
	always_ff @(posedge clk) begin
		adx_s1  <= ddx[32] ? (~ddx[31:0] + 32'd1) : ddx[31:0];
		ady_s1  <= ddy[32] ? (~ddy[31:0] + 32'd1) : ddy[31:0];
		sqx_s2  <= adx_s1 * adx_s1;
		sqy_s2  <= ady_s1 * ady_s1;
		dist_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire)
			in_q <= req.data;
		if (cmd.eval_init)
			thr2_q <= reach_q * reach_q;
		if (cmd.sq_wh) begin
			wsq_q <= in_q.object_width * in_q.object_width;
			hsq_q <= in_q.object_height * in_q.object_height;
		end
		if (cmd.root_init) begin
			val_q  <= {1'b0, {1'b0, wsq_q} + {1'b0, hsq_q}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			val_q <= {val_q[47:0], 2'b00};
			if (cand >= trial) begin
				rem_q  <= 27'(cand - trial);
				root_q <= {root_q[23:0], 1'b1};
			end else begin
				rem_q  <= cand[26:0];
				root_q <= {root_q[23:0], 1'b0};
			end
		end
		if (cmd.load_marks)
			marks_q <= mk_rd_q;
		else if (cmd.mark_near && below_thr)
			marks_q[k_q] <= 1'b1;
		if (cmd.pt_load) begin
			tgt_x_q <= pt_x;
			tgt_y_q <= pt_y;
		end else if (cmd.pt_centre) begin
			tgt_x_q <= ent_rd_q.cx;
			tgt_y_q <= ent_rd_q.cy;
		end
		if (cmd.best_upd && (!have_best_q || dist_lt_best)) begin
			best_q     <= dist_s3;
			best_idx_q <= idx_q[IDX_W-1:0];
		end
		if (cmd.fbest_upd && (!fhave_q || dist_lt_fbest)) begin
			fbest_q <= dist_s3;
			fpx_q   <= tgt_x_q;
			fpy_q   <= tgt_y_q;
		end
		if (cmd.pick)
			tgt_idx_q <= (active_valid_q && act_open_q) ? active_idx_q : best_idx_q;
		if (cmd.emit) begin
			out_q.goal_x      <= fpx_q;
			out_q.goal_y      <= fpy_q;
			out_q.goal_object <= ent_rd_q.id;
			if (dxneg) begin
				out_q.heading_z <= HZ_ONE;
				out_q.heading_w <= 15'd0;
			end else if (dypos) begin
				out_q.heading_z <= HZ_HALF;
				out_q.heading_w <= HW_HALF;
			end else if (dyneg) begin
				out_q.heading_z <= -HZ_HALF;
				out_q.heading_w <= HW_HALF;
			end else begin
				out_q.heading_z <= 16'sd0;
				out_q.heading_w <= HW_ONE;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			robot_x_q      <= '0;
			robot_y_q      <= '0;
			reach_q        <= REACH_RST;
			margin_q       <= MARGIN_RST;
			buffer_q       <= BUFFER_RST;
			count_q        <= '0;
			idx_q          <= '0;
			k_q            <= PT_NORTH;
			step_q         <= '0;
			have_best_q    <= 1'b0;
			fhave_q        <= 1'b0;
			act_open_q     <= 1'b0;
			active_valid_q <= 1'b0;
			active_idx_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			// configuration writes
			if (cfg.valid) begin
				case (cfg.data.index)
					CFG_REACH:  reach_q  <= cfg.data.value;
					CFG_MARGIN: margin_q <= cfg.data.value;
					CFG_BUFFER: buffer_q <= cfg.data.value;
					default:    reach_q  <= reach_q;
				endcase
			end
			if (cmd.set_pose) begin
				robot_x_q <= in_q.coord_x;
				robot_y_q <= in_q.coord_y;
			end
			// scan index
			if (cmd.scan_init || cmd.eval_init)
				idx_q <= '0;
			else if (cmd.inc_idx)
				idx_q <= idx_q + 1'b1;
			if (cmd.wr_entry)
				count_q <= count_q + 1'b1;
			// point index
			if (cmd.clr_k)
				k_q <= PT_NORTH;
			else if (cmd.inc_k)
				k_q <= k_q + 2'd1;
			if (cmd.root_init)
				step_q <= '0;
			else if (cmd.root_step)
				step_q <= step_q + 5'd1;
			// nearest centre and active object tracking
			if (cmd.eval_init) begin
				have_best_q <= 1'b0;
				act_open_q  <= 1'b0;
			end
			if (cmd.best_upd)
				have_best_q <= 1'b1;
			if (cmd.wr_marks && idx_q[IDX_W-1:0] == active_idx_q)
				act_open_q <= (marks_q != 4'hf);
			if (cmd.pick && !(active_valid_q && act_open_q)) begin
				active_valid_q <= have_best_q;
				if (have_best_q)
					active_idx_q <= best_idx_q;
			end
			if (cmd.clr_k)
				fhave_q <= 1'b0;
			else if (cmd.fbest_upd)
				fhave_q <= 1'b1;
			// result register
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	`NOVP_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_MAX, "count over table size")
	`NOVP_ASSERT_IMPL(a_wr_not_full, clk, arst_n, cmd.wr_entry, !full, "insert into full table")
	`NOVP_ASSERT_NEXT(a_count_step, clk, arst_n, cmd.wr_entry, count_q == $past(count_q) + 1'b1, "count step")
	`NOVP_ASSERT_IMPL(a_emit_slot, clk, arst_n, cmd.emit, out_free, "result overwritten")
	`NOVP_ASSERT_IMPL(a_emit_point, clk, arst_n, cmd.emit, fhave_q, "result without point")

endmodule

// ===== sv/nearest_object_visit_planner_core.sv =====
// Usage: items enter on req (valid/ready, one transfer per item): pose sets the
// robot position, marker adds an object, evaluate picks the next visit point.
// Results leave on rsp (valid/ready), at most one per evaluate, held in an
// output register until the receiver takes it. Registers are written on cfg
// (index, value); writes are always accepted and should occur while idle.
// A marker first searches the table for a duplicate id, reading and checking
// one stored object at a time, then squares width and height, sums them and
// takes the square root, which resolves one result bit a cycle. Evaluate walks
// the table once with a single three-stage squared-distance unit: for each
// stored object it reads the entry, tests each unvisited visit point and,
// if one stays open, the centre; it then rereads the target to pick a point.
// One item is processed at a time; req is ready only when the sequencer idles.
// If rsp stalls, a finished evaluate waits for the output register to free.
// Reset clears position, object count, active object and registers to their
// defaults; the table itself needs no clearing pass.
// ----------------------------------------------------------------------------
// nearest_object_visit_planner_core
// Top level: sequencer plus datapath of the nearest object visit planner.
// ----------------------------------------------------------------------------
module nearest_object_visit_planner_core #(
	parameter int MAX_OBJECTS = 64
) (
	input logic           clk,
	input logic           arst_n,
	novp_stream_if.sink   req,
	novp_stream_if.source rsp,
	novp_stream_if.sink   cfg
);
	import novp_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencer
	novp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	// datapath
	novp_dp #(
		.MAX_OBJECTS (MAX_OBJECTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.st     (st),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

endmodule

// ===== sim/tb_nearest_object_visit_planner_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_object_visit_planner_core
// Self-checking bench: a directed table of items, then random pose, marker,
// evaluate and invalid-code traffic. Every goal is checked against a behavioral planner.
// ----------------------------------------------------------------------------
module tb_nearest_object_visit_planner_core;
	import novp_pkg::*;

	localparam int N_OBJ = 64;
	localparam int N_RAND = 1750;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int END_WAIT = 2500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	novp_stream_if #(.payload_t(in_item_t))  req_if ();
	novp_stream_if #(.payload_t(out_item_t)) rsp_if ();
	novp_stream_if #(.payload_t(cfg_item_t)) cfg_if ();

	nearest_object_visit_planner_core #(.MAX_OBJECTS(N_OBJ)) dut (
		.clk(clk), .arst_n(arst_n), .req(req_if.sink), .rsp(rsp_if.source),
		.cfg(cfg_if.sink)
	);

	always #1 clk = ~clk;

	// planner copy of the block state
	logic [19:0] reach_q, margin_q, buffer_q;
	logic signed [31:0] pos_x, pos_y;
	int obj_cnt;
	logic signed [31:0] tab_id [N_OBJ];
	logic signed [31:0] tab_cx [N_OBJ];
	logic signed [31:0] tab_cy [N_OBJ];
	logic [24:0] tab_r [N_OBJ];
	logic [3:0] tab_marks [N_OBJ];
	logic act_valid;
	int act_idx;

	out_item_t goal_q [$];
	int errors = 0;
	int goals_seen = 0;
	int cycles = 0;
	logic watch_stop = 1'b0;

	// directed stimulus rows; expected goals typed in where obvious
	typedef struct {
		in_item_t it;
		bit chk;
		out_item_t g;
	} row_t;

	row_t rows [$];

	function automatic void add_row(input in_item_t it, input bit chk, input out_item_t g);
		row_t r;
		r.it = it;
		r.chk = chk;
		r.g = g;
		rows.insert(rows.size(), r);
	endfunction

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// exact squared distance, 65 bits
	function automatic logic [64:0] dist_sq(input longint ax, input longint ay,
			input longint bx, input longint by);
		longint dx, dy;
		logic [64:0] sx, sy;
		dx = ax - bx;
		dy = ay - by;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		sx = 65'(dx) * 65'(dx);
		sy = 65'(dy) * 65'(dy);
		return sx + sy;
	endfunction

	function automatic void visit_point(input int i, input int k,
			output logic signed [31:0] px, output logic signed [31:0] py);
		longint r;
		r = longint'(tab_r[i]);
		px = tab_cx[i];
		py = tab_cy[i];
		case (k)
			PT_NORTH: py = sat32(longint'(py) + r);
			PT_SOUTH: py = sat32(longint'(py) - r);
			PT_EAST:  px = sat32(longint'(px) + r);
			default:  px = sat32(longint'(px) - r);
		endcase
	endfunction

	// planner step; returns 1 when a goal is expected
	function automatic bit plan_item(input in_item_t it, output out_item_t g);
		logic [64:0] thr2, d, bd;
		logic signed [31:0] px, py;
		longint dx, dy;
		logic [63:0] w, h;
		int tgt, best, k;
		bit dup;
		g = '0;
		case (it.operation)
			OP_POSE: begin
				pos_x = it.coord_x;
				pos_y = it.coord_y;
				return 0;
			end
			OP_MARKER: begin
				if (!it.is_add) return 0;
				dup = 0;
				for (int i = 0; i < obj_cnt; i++)
					if (tab_id[i] == it.object_id) dup = 1;
				if (dup || obj_cnt >= N_OBJ) return 0;
				w = it.object_width;
				h = it.object_height;
				tab_id[obj_cnt] = it.object_id;
				tab_cx[obj_cnt] = it.coord_x;
				tab_cy[obj_cnt] = it.coord_y;
				tab_r[obj_cnt] = 25'(isqrt(w * w + h * h) >> 1) + margin_q + buffer_q;
				tab_marks[obj_cnt] = 4'h0;
				obj_cnt++;
				return 0;
			end
			OP_EVAL: begin
				thr2 = 65'(reach_q) * 65'(reach_q);
				for (int i = 0; i < obj_cnt; i++)
					for (int j = 0; j < 4; j++) begin
						if (tab_marks[i][j]) continue;
						visit_point(i, j, px, py);
						if (dist_sq(pos_x, pos_y, px, py) < thr2) tab_marks[i][j] = 1'b1;
					end
				tgt = -1;
				if (act_valid) begin
					if (act_idx < obj_cnt && tab_marks[act_idx] != 4'hf) tgt = act_idx;
					else act_valid = 0;
				end
				if (!act_valid) begin
					bd = '0;
					for (int i = 0; i < obj_cnt; i++) begin
						if (tab_marks[i] == 4'hf) continue;
						d = dist_sq(pos_x, pos_y, tab_cx[i], tab_cy[i]);
						if (tgt < 0 || d < bd) begin
							tgt = i;
							bd = d;
						end
					end
					if (tgt >= 0) begin
						act_valid = 1;
						act_idx = tgt;
					end
				end
				if (tgt < 0) return 0;
				best = -1;
				bd = '0;
				for (int j = 0; j < 4; j++) begin
					if (tab_marks[tgt][j]) continue;
					visit_point(tgt, j, px, py);
					d = dist_sq(pos_x, pos_y, px, py);
					if (best < 0 || d < bd) begin
						best = j;
						bd = d;
					end
				end
				if (best < 0) return 0;
				k = best;
				visit_point(tgt, k, px, py);
				dx = longint'(tab_cx[tgt]) - longint'(px);
				dy = longint'(tab_cy[tgt]) - longint'(py);
				g.goal_x = px;
				g.goal_y = py;
				g.goal_object = tab_id[tgt];
				if (dx < 0) begin
					g.heading_z = HZ_ONE; g.heading_w = '0;
				end else if (dy > 0) begin
					g.heading_z = HZ_HALF; g.heading_w = HW_HALF;
				end else if (dy < 0) begin
					g.heading_z = -HZ_HALF; g.heading_w = HW_HALF;
				end else begin
					g.heading_z = '0; g.heading_w = HW_ONE;
				end
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	// one item transfer, expected goal queued on acceptance; valid stays high
	// after the transfer until the next item or an explicit release
	task automatic send_item(input in_item_t it);
		out_item_t g;
		int gap;
		gap = $urandom_range(0, 7);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= it;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		if (plan_item(it, g)) goal_q.insert(goal_q.size(), g);
	endtask

	// wait until every goal is in, then let any trailing evaluate settle
	task automatic drain();
		req_if.valid <= 1'b0;
		while (goal_q.size() != 0) @(posedge clk);
		repeat (END_WAIT) @(posedge clk);
	endtask

	// register write; valid is released by the caller after the last write
	task automatic write_reg(input logic [1:0] idx, input logic [19:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= '{index: idx, value: v};
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		case (idx)
			CFG_REACH:  reach_q = v;
			CFG_MARGIN: margin_q = v;
			default:    buffer_q = v;
		endcase
	endtask

	function automatic in_item_t mk(input logic [1:0] op, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] id, input logic [23:0] w,
			input logic [23:0] h, input logic a);
		in_item_t it;
		it.operation = op; it.coord_x = x; it.coord_y = y; it.object_id = id;
		it.object_width = w; it.object_height = h; it.is_add = a;
		return it;
	endfunction

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7fff0000 + $urandom_range(0, 65535)
				: 32'h80000000 + $urandom_range(0, 65535);
			default: return 32'(signed'($urandom_range(0, 20 << 16)) - (10 << 16));
		endcase
	endfunction

	// receiver with random stall, compares against the oldest goal
	always @(posedge clk) begin
		out_item_t e, a;
		if (rsp_if.valid && rsp_if.ready) begin
			a = rsp_if.data;
			goals_seen++;
			if (goal_q.size() == 0) begin
				errors++;
				$display("%0t unexpected goal %p", $time, a);
			end else begin
				e = goal_q.pop_front();
				if (a.goal_x !== e.goal_x) begin
					errors++;
					$display("%0t goal_x exp %0d got %0d", $time, e.goal_x, a.goal_x);
				end
				if (a.goal_y !== e.goal_y) begin
					errors++;
					$display("%0t goal_y exp %0d got %0d", $time, e.goal_y, a.goal_y);
				end
				if (a.goal_object !== e.goal_object) begin
					errors++;
					$display("%0t goal_object exp %0d got %0d", $time, e.goal_object,
						a.goal_object);
				end
				if (a.heading_z !== e.heading_z) begin
					errors++;
					$display("%0t heading_z exp %0d got %0d", $time, e.heading_z,
						a.heading_z);
				end
				if (a.heading_w !== e.heading_w) begin
					errors++;
					$display("%0t heading_w exp %0d got %0d", $time, e.heading_w,
						a.heading_w);
				end
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (rsp_if.valid && rsp_if.ready || stall_left == 0 && !rsp_if.ready) begin
			if (rsp_if.valid && rsp_if.ready) stall_left = $urandom_range(0, 7);
			if (stall_left == 0) rsp_if.ready <= 1'b1;
			else rsp_if.ready <= 1'b0;
		end else if (!rsp_if.ready) begin
			stall_left--;
		end
	end

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT && !watch_stop) begin
			$display("%0t timeout", $time);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		out_item_t g;
		in_item_t it;
		int ops [3];
		int n_evals;
		req_if.valid = 1'b0;
		req_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		reach_q = REACH_RST; margin_q = MARGIN_RST; buffer_q = BUFFER_RST;
		pos_x = 0; pos_y = 0; obj_cnt = 0; act_valid = 0; act_idx = 0;
		for (int i = 0; i < N_OBJ; i++) begin
			tab_id[i] = 0; tab_cx[i] = 0; tab_cy[i] = 0; tab_r[i] = 0; tab_marks[i] = 0;
		end
		ops = '{0, 0, 0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then object at origin of size 0: radius = margin + buffer
		add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_MARKER, 0, 0, 5, 0, 0, 0), 0, '0);
		add_row(mk(OP_MARKER, 0, 0, 7, 0, 0, 1), 0, '0);
		add_row(mk(OP_MARKER, 32'h10000, 0, 7, 24'hffffff, 24'hffffff, 1), 0, '0);
		g = '{goal_x: 0, goal_y: 45875, goal_object: 7, heading_z: -HZ_HALF,
			heading_w: HW_HALF};
		add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0), 1, g);
		add_row(mk(2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 24'hffffff,
			24'hffffff, 1), 0, '0);
		// saturating extremes
		add_row(mk(OP_MARKER, 32'h7fffffff, 32'h80000000, 32'h80000000,
			24'hffffff, 0, 1), 0, '0);
		add_row(mk(OP_MARKER, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			0, 24'hffffff, 1), 0, '0);
		add_row(mk(OP_POSE, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_POSE, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0), 0, '0);
		// walk around the origin object until all points are visited
		add_row(mk(OP_POSE, 0, 45875, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_POSE, 0, -45875, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_POSE, 45875, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_POSE, -45875, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0), 0, '0);
		foreach (rows[r]) begin
			send_item(rows[r].it);
			if (rows[r].chk && (goal_q.size() == 0 || goal_q[$] != rows[r].g)) begin
				errors++;
				$display("%0t directed row %0d exp %p planner %p", $time, r, rows[r].g,
					goal_q.size() != 0 ? goal_q[$] : out_item_t'('0));
			end
		end
		drain();

		// random phases, each under its own register setting
		n_evals = 0;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_reg(CFG_REACH, 20'd0); write_reg(CFG_MARGIN, 20'd0);
					write_reg(CFG_BUFFER, 20'd0); end
				1: begin write_reg(CFG_REACH, 20'hfffff); write_reg(CFG_MARGIN, 20'hfffff);
					write_reg(CFG_BUFFER, 20'hfffff); end
				default: begin write_reg(CFG_REACH, 20'($urandom_range(0, 20'hfffff)));
					write_reg(CFG_MARGIN, 20'($urandom_range(0, 20'hfffff)));
					write_reg(CFG_BUFFER, 20'($urandom_range(0, 20'hfffff))); end
			endcase
			cfg_if.valid <= 1'b0;
			for (int n = 0; n < N_RAND / 5; n++) begin
				it = '0;
				it.coord_x = rnd_coord();
				it.coord_y = rnd_coord();
				it.object_width = $urandom_range(0, 3) == 0 ? 24'($urandom())
					: 24'($urandom_range(0, 4 << 16));
				it.object_height = $urandom_range(0, 3) == 0 ? 24'($urandom())
					: 24'($urandom_range(0, 4 << 16));
				it.object_id = $urandom_range(0, 7) == 0 ? $urandom()
					: 32'($urandom_range(0, 90));
				it.is_add = $urandom_range(0, 7) != 0;
				case ($urandom_range(0, 19))
					0: it.operation = 2'd3;
					1, 2, 3, 4, 5, 6: it.operation = OP_POSE;
					7, 8, 9, 10, 11: it.operation = OP_MARKER;
					default: it.operation = OP_EVAL;
				endcase
				// keep the table small most of the time so evaluates stay short
				if (it.operation == OP_MARKER && obj_cnt >= 12 && ph != 4)
					it.operation = OP_EVAL;
				if (it.operation != 2'd3) ops[it.operation]++;
				if (it.operation == OP_EVAL) n_evals++;
				send_item(it);
				// sender holds off until the pipe is empty
				if (n == 100) begin
					req_if.valid <= 1'b0;
					while (goal_q.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		watch_stop = 1'b1;
		$display("covered %0d pose, %0d marker, %0d evaluate items; %0d goals, %0d objects",
			ops[0], ops[1], n_evals, goals_seen, obj_cnt);
		$display("five register settings including all-zero and all-ones");
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/novp_pkg.sv
sv/novp_stream_if.sv
sv/novp_ctrl.sv
sv/novp_dp.sv
sv/nearest_object_visit_planner_core.sv
sim/tb_nearest_object_visit_planner_core.sv
